/* hw/rtl/tct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int KEY_W   = 16;
  localparam int POS_W   = 16;
  localparam int LIFE_W  = 8;
  localparam int BASE_W  = 10;
  localparam int ID_W    = 11;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LIFE_RELOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX  = 2'd1;

  localparam logic [LIFE_W-1:0] LIFE_RESET = 8'd5;

  // Event codes
  localparam logic [KIND_W-1:0] EV_DOWN  = 2'd0;
  localparam logic [KIND_W-1:0] EV_MOVED = 2'd1;
  localparam logic [KIND_W-1:0] EV_UP    = 2'd2;
  localparam logic [KIND_W-1:0] EV_DROP  = 2'd3;

  // Request codes
  localparam logic REQ_MSG  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSG,
    ST_TICK
  } state_t;

  typedef enum logic [1:0] {
    OSEL_HIT,
    OSEL_APPEND,
    OSEL_DROP,
    OSEL_PEND
  } out_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     step;
    logic     msg_write;
    logic     append;
    logic     tick_dec;
    logic     pend_load;
    logic     pend_clear;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_end;
    logic hit;
    logic full;
    logic life_zero;
    logic life_one;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/touch_cursor_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Remote touch cursor table.
// Input channel (in_valid / in_stall) carries one request: a cursor message
// (req_type 0) with sender address, cursor number and position, or a frame
// tick (req_type 1). A message reports touch down, touch moved, or dropped
// when the table is full: always one result with last set. A tick reports
// touch up for each entry whose life runs out, last set on the final one,
// and nothing when none expires.
// Output channel (out_valid / out_stall) is a single output register; a
// result waits there while the receiver stalls and the walk pauses only when
// a further result is ready for it.
// Flow: a message walks the occupied slots one slot per cycle, comparing each,
// until it hits or reaches the end; a tick walks every occupied slot and
// also pauses while the receiver stalls. One request is handled at a time.
// Configuration: cfg_valid / cfg_ready write the life reload value (index 0)
// or base_index (index 1); cfg_ready is always high. Write only while idle.
// Reset empties the table and loads a life reload of 5 and base_index 0.

module touch_cursor_tracker
  import tct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [ADDR_W-1:0]     sender_addr,
  input  wire logic [KEY_W-1:0]      cursor_key,
  input  wire logic [POS_W-1:0]      pos_x,
  input  wire logic [POS_W-1:0]      pos_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [KIND_W-1:0]          event_kind,
  output logic [ID_W-1:0]            touch_id,
  output logic [POS_W-1:0]           out_x,
  output logic [POS_W-1:0]           out_y,
  output logic                       last
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  tct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_req_type (req_type),
    .in_stall    (in_stall),
    .st          (st),
    .cmd         (cmd)
  );

  tct_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sender_addr (sender_addr),
    .cursor_key  (cursor_key),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .event_kind  (event_kind),
    .touch_id    (touch_id),
    .out_x       (out_x),
    .out_y       (out_y),
    .last        (last),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

`default_nettype wire

/* hw/rtl/tct_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tct_ctrl
  import tct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_req_type,
  output logic       in_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_req_type == REQ_TICK) ? ST_TICK : ST_MSG;
        end
      end
      ST_MSG: begin
        if ((st.hit || st.scan_end) && st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (st.scan_end && (!st.pend_valid || st.out_free)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd          = '0;
    cmd.out_sel  = OSEL_HIT;
    in_stall     = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_MSG: begin
        if (st.hit) begin
          // update the matching entry and report a move
          if (st.out_free) begin
            cmd.msg_write = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_sel   = OSEL_HIT;
            cmd.out_last  = 1'b1;
          end
        end else if (st.scan_end) begin
          // append a new entry, or drop when the table is full
          if (st.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (st.full) begin
              cmd.out_sel = OSEL_DROP;
            end else begin
              cmd.out_sel   = OSEL_APPEND;
              cmd.msg_write = 1'b1;
              cmd.append    = 1'b1;
            end
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_TICK: begin
        if (st.scan_end) begin
          // flush the held touch-up as the final result
          if (st.pend_valid && st.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_sel    = OSEL_PEND;
            cmd.out_last   = 1'b1;
            cmd.pend_clear = 1'b1;
          end
        end else if (st.life_zero) begin
          cmd.step = 1'b1;
        end else if (!st.life_one) begin
          cmd.tick_dec = 1'b1;
          cmd.step     = 1'b1;
        end else if (!st.pend_valid || st.out_free) begin
          // entry expires: release any held touch-up, hold this one
          cmd.tick_dec  = 1'b1;
          cmd.step      = 1'b1;
          cmd.pend_load = 1'b1;
          if (st.pend_valid) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OSEL_PEND;
            cmd.out_last = 1'b0;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/tct_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tct_dp
  import tct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ADDR_W-1:0]     sender_addr,
  input  wire logic [KEY_W-1:0]      cursor_key,
  input  wire logic [POS_W-1:0]      pos_x,
  input  wire logic [POS_W-1:0]      pos_y,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [KIND_W-1:0]          event_kind,
  output logic [ID_W-1:0]            touch_id,
  output logic [POS_W-1:0]           out_x,
  output logic [POS_W-1:0]           out_y,
  output logic                       last,
  input  wire cmd_t                  cmd,
  output stat_t                      st
);

  logic [LIFE_W-1:0] life_reload;
  logic [BASE_W-1:0] base_index;

  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] slot;

  logic [ADDR_W-1:0] entry_sender [TABLE_DEPTH];
  logic [KEY_W-1:0]  entry_cursor [TABLE_DEPTH];
  logic [POS_W-1:0]  entry_xpos   [TABLE_DEPTH];
  logic [POS_W-1:0]  entry_ypos   [TABLE_DEPTH];
  logic [LIFE_W-1:0] entry_life   [TABLE_DEPTH];

  logic [ADDR_W-1:0] q_sender;
  logic [KEY_W-1:0]  q_cursor;
  logic [POS_W-1:0]  q_x;
  logic [POS_W-1:0]  q_y;

  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic [POS_W-1:0]  pend_x;
  logic [POS_W-1:0]  pend_y;

  logic [ID_W-1:0]   slot_id;
  logic [LIFE_W-1:0] cur_life;

  assign slot     = idx[SLOT_W-1:0];
  assign cur_life = entry_life[slot];
  assign slot_id  = ID_W'(base_index) + ID_W'(idx);

  // Status toward the controller
  always_comb begin
    st.scan_end   = (idx >= entry_count);
    st.hit        = !st.scan_end && (entry_sender[slot] == q_sender) &&
                    (entry_cursor[slot] == q_cursor);
    st.full       = (entry_count == CNT_W'(TABLE_DEPTH));
    st.life_zero  = (cur_life == '0);
    st.life_one   = (cur_life == LIFE_W'(1));
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || !out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      life_reload <= LIFE_RESET;
      base_index  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIFE_RELOAD: life_reload <= cfg_data[LIFE_W-1:0];
        CFG_BASE_INDEX:  base_index  <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_sender <= sender_addr;
      q_cursor <= cursor_key;
      q_x      <= pos_x;
      q_y      <= pos_y;
    end
  end

  // Scan index and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // Table writes at the scan slot
  always_ff @(posedge clk) begin
    if (cmd.msg_write) begin
      entry_xpos[slot] <= q_x;
      entry_ypos[slot] <= q_y;
      entry_life[slot] <= life_reload;
    end else if (cmd.tick_dec) begin
      entry_life[slot] <= cur_life - LIFE_W'(1);
    end
    if (cmd.append) begin
      entry_sender[slot] <= q_sender;
      entry_cursor[slot] <= q_cursor;
    end
  end

  // Held touch-up, released once the next one or the scan end is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
    end else if (cmd.pend_clear) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_id <= slot_id;
      pend_x  <= entry_xpos[slot];
      pend_y  <= entry_ypos[slot];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_HIT: begin
          event_kind <= EV_MOVED;
          touch_id   <= slot_id;
          out_x      <= q_x;
          out_y      <= q_y;
        end
        OSEL_APPEND: begin
          event_kind <= EV_DOWN;
          touch_id   <= slot_id;
          out_x      <= q_x;
          out_y      <= q_y;
        end
        OSEL_DROP: begin
          event_kind <= EV_DROP;
          touch_id   <= '0;
          out_x      <= q_x;
          out_y      <= q_y;
        end
        OSEL_PEND: begin
          event_kind <= EV_UP;
          touch_id   <= pend_id;
          out_x      <= pend_x;
          out_y      <= pend_y;
        end
        default: begin
          event_kind <= EV_DROP;
          touch_id   <= '0;
          out_x      <= q_x;
          out_y      <= q_y;
        end
      endcase
    end
  end

  // Fill count never passes the table size
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Scan never runs past the occupied slots
  assert property (@(posedge clk) disable iff (rst)
    idx <= entry_count)
    else $error("scan index beyond entry count");

  // An output is never loaded over a result that is still stalled
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output overwritten while stalled");

  // Append happens only at the end of a miss scan with room left
  assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (st.scan_end && !st.full))
    else $error("append outside a miss with free slot");

endmodule

`default_nettype wire
